// File: hdl/rwul_pkg.sv
package rwul_pkg;

    // Sizes of the lock state
    localparam int ID_BITS     = 4;
    localparam int REQ_W       = 4;
    localparam int CNT_W       = 8;
    localparam int MAX_READERS = 255;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;
    localparam int READER_CAP  = (MAX_READERS > CNT_MAX) ? CNT_MAX : MAX_READERS;

    typedef enum logic [2:0] {
        KIND_READ      = 3'd0,
        KIND_RIW       = 3'd1,
        KIND_WRITE     = 3'd2,
        KIND_JUSTWRITE = 3'd3,
        KIND_UNLOCK    = 3'd4,
        KIND_HOLD      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_RIW   = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_WAIT = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        WAKE_NONE = 2'd0,
        WAKE_ONE  = 2'd1,
        WAKE_ALL  = 2'd2
    } wake_t;

    // One request word
    typedef struct packed {
        logic [2:0]       kind;
        logic [REQ_W-1:0] requester;
    } req_t;

    // Request word held in the input register, with its valid flag
    typedef struct packed {
        logic vld;
        req_t word;
    } stage_t;

endpackage

// File: hdl/rwul_req_if.sv
interface rwul_req_if
    import rwul_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [2:0]       kind;
    logic [REQ_W-1:0] requester;

    modport source (output valid, output kind, output requester, input ready);
    modport sink   (input valid, input kind, input requester, output ready);
endinterface

// File: hdl/rwul_rsp_if.sv
interface rwul_rsp_if
    import rwul_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             held;
    logic [1:0]       wake;
    logic [1:0]       mode_now;
    logic [CNT_W-1:0] readers_now;

    modport source (output valid, output status, output held, output wake,
                    output mode_now, output readers_now, input ready);
    modport sink   (input valid, input status, input held, input wake,
                    input mode_now, input readers_now, output ready);
endinterface

// File: hdl/rwul_in_stage.sv
module rwul_in_stage
    import rwul_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rwul_req_if.sink   req,
    input  logic       take,
    output stage_t     stage
);

    logic vld_reg;
    logic vld_next;
    req_t word_reg;
    logic accept;

    // Room in the register when it is empty or drains this cycle.
    assign req.ready = !vld_reg || take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= '{kind: req.kind, requester: req.requester};
        end
    end

    assign stage.vld  = vld_reg;
    assign stage.word = word_reg;

endmodule

// File: hdl/rwul_core.sv
module rwul_core
    import rwul_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     stage,
    output logic       take,
    rwul_rsp_if.source rsp
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(READER_CAP);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    mode_t              mode_reg,  mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_BITS-1:0] owner_reg, owner_next;

    logic               rvld_reg, rvld_next;
    status_t            status_reg, status_next;
    logic               held_reg, held_next;
    wake_t              wake_reg, wake_next;

    logic [ID_BITS-1:0] who;
    logic               is_owner;
    logic [CNT_W-1:0]   dec;
    logic               fire;

    // The result register frees up when empty or when the word is taken.
    assign take = !rvld_reg || rsp.ready;
    assign fire = stage.vld && take;

    assign who      = stage.word.requester[ID_BITS-1:0];
    assign is_owner = (who == owner_reg);
    assign dec      = (count_reg != '0) ? (count_reg - ONE) : '0;

    // Lock decision for one request.
    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        owner_next  = owner_reg;
        status_next = ST_OK;
        held_next   = 1'b0;
        wake_next   = WAKE_NONE;
        case (stage.word.kind)
            KIND_READ:
            begin
                if (mode_reg == MODE_WRITE || count_reg >= CAP)
                begin
                    status_next = ST_WAIT;
                end
                else
                begin
                    count_next = count_reg + ONE;
                    if (mode_reg == MODE_FREE)
                    begin
                        mode_next = MODE_READ;
                    end
                end
            end
            KIND_RIW:
            begin
                if (mode_reg == MODE_WRITE || mode_reg == MODE_RIW || count_reg >= CAP)
                begin
                    status_next = ST_WAIT;
                end
                else
                begin
                    count_next = count_reg + ONE;
                    mode_next  = MODE_RIW;
                    owner_next = who;
                end
            end
            KIND_WRITE:
            begin
                if (mode_reg != MODE_RIW || !is_owner)
                begin
                    status_next = ST_ERR;
                end
                else if (count_reg > ONE)
                begin
                    status_next = ST_WAIT;
                end
                else
                begin
                    count_next = '0;
                    mode_next  = MODE_WRITE;
                end
            end
            KIND_JUSTWRITE:
            begin
                if (mode_reg == MODE_FREE && count_reg == '0)
                begin
                    mode_next  = MODE_WRITE;
                    owner_next = who;
                end
                else
                begin
                    status_next = ST_WAIT;
                end
            end
            KIND_UNLOCK:
            begin
                case (mode_reg)
                    MODE_FREE:
                    begin
                        status_next = ST_ERR;
                    end
                    MODE_READ:
                    begin
                        count_next = dec;
                        if (dec == '0)
                        begin
                            mode_next = MODE_FREE;
                            wake_next = WAKE_ONE;
                        end
                    end
                    MODE_RIW:
                    begin
                        if (dec == '0)
                        begin
                            if (!is_owner)
                            begin
                                status_next = ST_ERR;
                            end
                            else
                            begin
                                count_next = '0;
                                mode_next  = MODE_FREE;
                                wake_next  = WAKE_ALL;
                            end
                        end
                        else
                        begin
                            count_next = dec;
                            if (is_owner)
                            begin
                                mode_next = MODE_READ;
                            end
                        end
                    end
                    default:
                    begin
                        // Write mode: only the owner may release.
                        if (!is_owner)
                        begin
                            status_next = ST_ERR;
                        end
                        else
                        begin
                            count_next = '0;
                            mode_next  = MODE_FREE;
                            wake_next  = WAKE_ALL;
                        end
                    end
                endcase
            end
            KIND_HOLD:
            begin
                held_next = (mode_reg == MODE_RIW || mode_reg == MODE_WRITE) && is_owner;
            end
            default:
            begin
                status_next = ST_ERR;
            end
        endcase
    end

    assign rvld_next = stage.vld || (rvld_reg && !rsp.ready);

    // Lock state and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FREE;
            count_reg <= '0;
            owner_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            rvld_reg <= rvld_next;
            if (fire)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                owner_reg <= owner_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            held_reg   <= held_next;
            wake_reg   <= wake_next;
        end
    end

    assign rsp.valid       = rvld_reg;
    assign rsp.status      = status_reg;
    assign rsp.held        = held_reg;
    assign rsp.wake        = wake_reg;
    assign rsp.mode_now    = mode_reg;
    assign rsp.readers_now = count_reg;

endmodule

// File: hdl/reader_writer_upgrade_lock_top.sv
// Reader/writer lock with upgrade.
//
// The req channel carries one request word per handshake: kind (read, riw,
// write upgrade, justwrite, unlock, hold query) and the requester id. The
// rsp channel returns exactly one word per request: status, held, wake,
// and the mode and reader count as they stand after the request.
//
// A word accepted from req is loaded into the input register; its answer
// lands in the result register when the core takes it, together with the
// update of the lock state. Throughput is one request per cycle while
// rsp.ready stays high, set by the read-modify-write of the mode, count
// and owner registers.
//
// Reset frees the lock with no readers and owner zero, and empties both
// registers. When the receiver holds rsp.ready low the result word stays,
// the input register fills, and then req.ready drops until a word is taken.
module reader_writer_upgrade_lock_top
    import rwul_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rwul_req_if.sink   req,
    rwul_rsp_if.source rsp
);

    stage_t stage;
    logic   take;

    rwul_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .stage (stage)
    );

    rwul_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .rsp   (rsp)
    );

endmodule

// File: hdl/rwul_checker.sv
module rwul_checker
    import rwul_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [1:0]       rsp_status,
    input logic             rsp_held,
    input logic [1:0]       rsp_wake,
    input logic [1:0]       rsp_mode_now,
    input logic [CNT_W-1:0] rsp_readers_now
);

    // A stalled result word must keep its status and wake.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_wake))
        else $error("result word changed while stalled");

    // Holding implies a riw or write mode.
    a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_held |-> rsp_mode_now == MODE_RIW || rsp_mode_now == MODE_WRITE)
        else $error("held reported with no exclusive mode");

    // A wakeup only comes from a successful release.
    a_wake_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_wake != WAKE_NONE |-> rsp_mode_now == MODE_FREE && rsp_status == ST_OK)
        else $error("wake reported without freeing the lock");

    // A free or write-held lock has no readers.
    a_no_readers: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_mode_now == MODE_FREE || rsp_mode_now == MODE_WRITE)
        |-> rsp_readers_now == '0)
        else $error("readers counted while free or write-held");

endmodule

bind reader_writer_upgrade_lock_top rwul_checker u_rwul_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_held        (rsp.held),
    .rsp_wake        (rsp.wake),
    .rsp_mode_now    (rsp.mode_now),
    .rsp_readers_now (rsp.readers_now)
);
